### hw/rtl/hdgs_pkg.sv
`timescale 1ns / 1ps

package hdgs_pkg;

  localparam int STEP_BITS    = 10;
  localparam int GAMMA_BITS   = 7;
  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_DW       = 10;
  localparam int OUT_IDX_BITS = 3;
  localparam int Q_FRAC       = 8;

  localparam logic [STEP_BITS-1:0]  STEP_RESET  = 10'd99;
  localparam logic [GAMMA_BITS-1:0] GAMMA_RESET = 7'd64;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_STEP_COUNT = 2'd0,
    CFG_GAMMA      = 2'd1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_LOAD = 2'd0,
    ST_STEP = 2'd1,
    ST_EMIT = 2'd2
  } state_e;

  // control that travels with the read data of one sweep cycle
  typedef struct packed {
    logic shift;     // read data arrives, advance the window
    logic ctr;       // a center cell is complete, produce its new value
    logic interior;  // center cell is not on the border
    logic wbank;     // bank that receives the new value
  } stn_ctl_t;

  typedef struct packed {
    logic we;
    logic bank;
  } stn_wr_t;

endpackage

### hw/rtl/hdgs_ram.sv
`timescale 1ns / 1ps

module hdgs_ram #(
  parameter int WIDTH = 7,
  parameter int DEPTH = 49,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/hdgs_stencil.sv
`timescale 1ns / 1ps

module hdgs_stencil
  import hdgs_pkg::*;
#(
  parameter int GRID_SIZE = 7,
  parameter int TEMP_BITS = 7,
  localparam int AW       = $clog2(GRID_SIZE * GRID_SIZE)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  stn_ctl_t              ctl_i,
  input  logic [AW-1:0]         addr_i,
  input  logic [TEMP_BITS-1:0]  rdata_i,
  input  logic [GAMMA_BITS-1:0] gamma_i,
  output stn_wr_t               wr_o,
  output logic [AW-1:0]         wr_addr_o,
  output logic [TEMP_BITS-1:0]  wr_data_o
);

  localparam int WL = 2 * GRID_SIZE;
  localparam int DW = TEMP_BITS + 3;
  localparam int PW = DW + GAMMA_BITS + 1;
  localparam logic [TEMP_BITS-1:0] TMAX = '1;

  // win_q[k] holds the read data taken k+1 window shifts before the current read data
  logic [TEMP_BITS-1:0] win_q [WL];
  logic [TEMP_BITS-1:0] u, up_v, lf_v, rt_v;
  logic [DW-1:0]        nb_sum, diff;
  logic signed [PW-1:0] prod_d;

  logic                 p2_vld_q, p2_int_q, p2_bank_q;
  logic [AW-1:0]        p2_addr_q;
  logic [TEMP_BITS-1:0] p2_u_q;
  logic signed [PW-1:0] p2_prod_q;
  logic signed [PW-1:0] p2_shift, p2_sum;
  logic [TEMP_BITS-1:0] clamp;

  assign u    = win_q[GRID_SIZE-1];
  assign up_v = win_q[WL-1];
  assign lf_v = win_q[GRID_SIZE];
  assign rt_v = win_q[GRID_SIZE-2];

  always_comb begin
    nb_sum = DW'(up_v) + DW'(rdata_i) + DW'(lf_v) + DW'(rt_v);
    diff   = nb_sum - (DW'(u) << 2);
    prod_d = PW'($signed(diff)) * PW'($signed({1'b0, gamma_i}));
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.shift) begin
      win_q[0] <= rdata_i;
      for (int k = 1; k < WL; k++) begin
        win_q[k] <= win_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_vld_q <= 1'b0;
    end else begin
      p2_vld_q <= ctl_i.ctr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ctr) begin
      p2_int_q  <= ctl_i.interior;
      p2_bank_q <= ctl_i.wbank;
      p2_addr_q <= addr_i;
      p2_u_q    <= u;
      p2_prod_q <= prod_d;
    end
  end

  // arithmetic shift floors toward minus infinity
  always_comb begin
    p2_shift = p2_prod_q >>> Q_FRAC;
    p2_sum   = p2_shift + $signed(PW'(p2_u_q));
    if (p2_sum[PW-1]) begin
      clamp = '0;
    end else if (p2_sum > $signed(PW'(TMAX))) begin
      clamp = TMAX;
    end else begin
      clamp = p2_sum[TEMP_BITS-1:0];
    end
  end

  assign wr_o.we   = p2_vld_q;
  assign wr_o.bank = p2_bank_q;
  assign wr_addr_o = p2_addr_q;
  assign wr_data_o = p2_int_q ? clamp : p2_u_q;

endmodule

### hw/rtl/heat_diffusion_grid_stencil_unit.sv
`timescale 1ns / 1ps
// Channel  Dir  Carries
// s_axis   in   tdata: cell_temperature, one cell per transfer, row-major
// m_axis   out  tdata: result_temperature, result_row, result_column; tlast: last_cell
// cfg      in   cfg_idx_i 0: step_count, 1: gamma_q8
//
// Load takes one cycle per cell. Each time step is one sweep over the grid: one read a cycle
// from the current grid memory through a 2*GRID_SIZE tap window, one write a cycle into the
// other memory. Emission reads each cell and then registers it; the next read waits for that.
// Reset clears control only; the grid memories need no clearing pass.
// A stalled m_axis holds the emitter; loading of the next grid can overlap the last transfer.

module heat_diffusion_grid_stencil_unit
  import hdgs_pkg::*;
#(
  parameter int GRID_SIZE = 7,
  parameter int TEMP_BITS = 7,
  localparam int IDW      = ((TEMP_BITS + 7) / 8) * 8,
  localparam int ODW      = ((TEMP_BITS + 2 * OUT_IDX_BITS + 7) / 8) * 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [IDW-1:0]          s_axis_tdata,   // [TEMP_BITS-1:0] cell_temperature
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [ODW-1:0]          m_axis_tdata,   // result_temperature, result_row, result_column
  output logic                    m_axis_tlast,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [CFG_DW-1:0]       cfg_wdata_i
);

  localparam int CELLS = GRID_SIZE * GRID_SIZE;
  localparam int AW   = $clog2(CELLS);
  localparam int TW   = $clog2(CELLS + GRID_SIZE);
  localparam int RW   = $clog2(GRID_SIZE + 1);

  state_e state_q, state_d;

  logic [STEP_BITS-1:0]  steps_q, sc_q, sc_d;
  logic [GAMMA_BITS-1:0] gamma_q;
  logic                  cur_q, cur_d;
  logic [AW-1:0]         ld_q, ld_d;
  logic [TW-1:0]         t_q, t_d;
  logic [RW-1:0]         irow_q, irow_d, icol_q, icol_d;
  logic [AW-1:0]         e_q, e_d;
  logic [RW-1:0]         erow_q, erow_d, ecol_q, ecol_d;
  logic                  em_pend_q;

  logic                  out_vld_q, out_vld_d;
  logic [TEMP_BITS-1:0]  out_temp_q;
  logic [OUT_IDX_BITS-1:0] out_row_q, out_col_q;
  logic                  out_last_q;

  stn_ctl_t              s1_ctl_q, s1_ctl_d;
  logic [AW-1:0]         s1_addr_q;

  logic ld_acc, ld_last, step_re, step_end, em_issue, em_last, interior;
  logic [AW-1:0]        raddr;
  logic [TEMP_BITS-1:0] rdata0, rdata1, stn_rdata, em_rdata;

  stn_wr_t              stn_wr;
  logic [AW-1:0]        stn_waddr;
  logic [TEMP_BITS-1:0] stn_wdata;

  logic                 we0, we1, re0, re1;
  logic [AW-1:0]        waddr0, waddr1;
  logic [TEMP_BITS-1:0] wdata0, wdata1;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steps_q <= STEP_RESET;
      gamma_q <= GAMMA_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_STEP_COUNT: steps_q <= cfg_wdata_i[STEP_BITS-1:0];
        CFG_GAMMA:      gamma_q <= cfg_wdata_i[GAMMA_BITS-1:0];
        default: ;
      endcase
    end
  end

  // control outputs
  always_comb begin
    s_axis_tready = 1'b0;
    step_re       = 1'b0;
    em_issue      = 1'b0;
    unique case (state_q)
      ST_LOAD: s_axis_tready = 1'b1;
      ST_STEP: step_re  = (t_q < TW'(CELLS));
      ST_EMIT: em_issue = !em_pend_q && (!out_vld_q || m_axis_tready);
      default: ;
    endcase
  end

  assign ld_acc   = s_axis_tvalid && s_axis_tready;
  assign ld_last  = (ld_q == AW'(CELLS - 1));
  assign step_end = (state_q == ST_STEP) && (t_q == TW'(CELLS + GRID_SIZE - 1));
  assign em_last  = (e_q == AW'(CELLS - 1));
  assign interior = (irow_q >= RW'(2)) && (irow_q <= RW'(GRID_SIZE - 1)) &&
                    (icol_q >= RW'(1)) && (icol_q <= RW'(GRID_SIZE - 2));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD: begin
        if (ld_acc && ld_last) begin
          state_d = (steps_q == '0) ? ST_EMIT : ST_STEP;
        end
      end
      ST_STEP: begin
        if (step_end && (sc_q + STEP_BITS'(1) == steps_q)) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (em_issue && em_last) begin
          state_d = ST_LOAD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  // counters
  always_comb begin
    ld_d   = ld_q;
    t_d    = t_q;
    irow_d = irow_q;
    icol_d = icol_q;
    sc_d   = sc_q;
    cur_d  = cur_q;
    e_d    = e_q;
    erow_d = erow_q;
    ecol_d = ecol_q;

    if (ld_acc) begin
      ld_d = ld_last ? '0 : ld_q + AW'(1);
    end

    if (state_q == ST_STEP) begin
      if (step_end) begin
        t_d    = '0;
        irow_d = '0;
        icol_d = '0;
        cur_d  = !cur_q;
        sc_d   = (sc_q + STEP_BITS'(1) == steps_q) ? '0 : sc_q + STEP_BITS'(1);
      end else begin
        t_d = t_q + TW'(1);
        if (icol_q == RW'(GRID_SIZE - 1)) begin
          icol_d = '0;
          irow_d = irow_q + RW'(1);
        end else begin
          icol_d = icol_q + RW'(1);
        end
      end
    end

    if (em_issue) begin
      if (em_last) begin
        e_d    = '0;
        erow_d = '0;
        ecol_d = '0;
      end else begin
        e_d = e_q + AW'(1);
        if (ecol_q == RW'(GRID_SIZE - 1)) begin
          ecol_d = '0;
          erow_d = erow_q + RW'(1);
        end else begin
          ecol_d = ecol_q + RW'(1);
        end
      end
    end
  end

  // read data of this sweep cycle arrives next cycle, with its control
  always_comb begin
    s1_ctl_d.shift    = (state_q == ST_STEP);
    s1_ctl_d.ctr      = (state_q == ST_STEP) && (irow_q != '0);
    s1_ctl_d.interior = interior;
    s1_ctl_d.wbank    = !cur_q;
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (em_pend_q) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_LOAD;
      ld_q      <= '0;
      t_q       <= '0;
      irow_q    <= '0;
      icol_q    <= '0;
      sc_q      <= '0;
      cur_q     <= 1'b0;
      e_q       <= '0;
      erow_q    <= '0;
      ecol_q    <= '0;
      em_pend_q <= 1'b0;
      out_vld_q <= 1'b0;
      s1_ctl_q  <= '0;
    end else begin
      state_q   <= state_d;
      ld_q      <= ld_d;
      t_q       <= t_d;
      irow_q    <= irow_d;
      icol_q    <= icol_d;
      sc_q      <= sc_d;
      cur_q     <= cur_d;
      e_q       <= e_d;
      erow_q    <= erow_d;
      ecol_q    <= ecol_d;
      em_pend_q <= em_issue;
      out_vld_q <= out_vld_d;
      s1_ctl_q  <= s1_ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_addr_q <= AW'(t_q - TW'(GRID_SIZE));
    // the slot is free or being taken at this edge
    if (em_issue) begin
      out_row_q  <= OUT_IDX_BITS'(erow_q);
      out_col_q  <= OUT_IDX_BITS'(ecol_q);
      out_last_q <= em_last;
    end
    if (em_pend_q) begin
      out_temp_q <= em_rdata;
    end
  end

  // memory ports
  assign raddr  = step_re ? t_q[AW-1:0] : e_q;
  assign re0    = (step_re || em_issue) && !cur_q;
  assign re1    = (step_re || em_issue) && cur_q;
  assign we0    = (ld_acc && !cur_q) || (stn_wr.we && !stn_wr.bank);
  assign we1    = (ld_acc && cur_q) || (stn_wr.we && stn_wr.bank);
  assign waddr0 = ld_acc ? ld_q : stn_waddr;
  assign waddr1 = ld_acc ? ld_q : stn_waddr;
  assign wdata0 = ld_acc ? s_axis_tdata[TEMP_BITS-1:0] : stn_wdata;
  assign wdata1 = ld_acc ? s_axis_tdata[TEMP_BITS-1:0] : stn_wdata;

  assign stn_rdata = s1_ctl_q.wbank ? rdata0 : rdata1;
  assign em_rdata  = cur_q ? rdata1 : rdata0;

  hdgs_ram #(
    .WIDTH (TEMP_BITS),
    .DEPTH (CELLS)
  ) u_grid0 (
    .clk_i   (clk_i),
    .we_i    (we0),
    .waddr_i (waddr0),
    .wdata_i (wdata0),
    .re_i    (re0),
    .raddr_i (raddr),
    .rdata_o (rdata0)
  );

  hdgs_ram #(
    .WIDTH (TEMP_BITS),
    .DEPTH (CELLS)
  ) u_grid1 (
    .clk_i   (clk_i),
    .we_i    (we1),
    .waddr_i (waddr1),
    .wdata_i (wdata1),
    .re_i    (re1),
    .raddr_i (raddr),
    .rdata_o (rdata1)
  );

  hdgs_stencil #(
    .GRID_SIZE (GRID_SIZE),
    .TEMP_BITS (TEMP_BITS)
  ) u_stencil (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (s1_ctl_q),
    .addr_i    (s1_addr_q),
    .rdata_i   (stn_rdata),
    .gamma_i   (gamma_q),
    .wr_o      (stn_wr),
    .wr_addr_o (stn_waddr),
    .wr_data_o (stn_wdata)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = ODW'({out_col_q, out_row_q, out_temp_q});
  assign m_axis_tlast  = out_last_q;

  // the sweep pipeline has drained long before a new grid loads
  a_no_step_write_in_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOAD) |-> !stn_wr.we)
    else $error("stencil write while loading");

  // at a step boundary the tail writes must never hit a cell the next sweep reads
  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stn_wr.we && step_re && (stn_wr.bank == cur_q)) |-> (stn_waddr != raddr))
    else $error("sweep read overlaps pending write");

  a_load_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ld_q <= AW'(CELLS - 1))
    else $error("load position out of range");

  // a captured cell always lands in a free output slot
  a_emit_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    em_pend_q |-> !out_vld_q || $past(m_axis_tready))
    else $error("emitter overwrote a pending transfer");

endmodule

### verif/stencil_checker.sv
`timescale 1ns / 1ps

module stencil_checker
  import hdgs_pkg::*;
#(
  parameter int GRID   = 7,
  parameter int TEMP_W = 7
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cell_tvalid_i,
  input  logic                    cell_tready_i,
  input  logic [7:0]              cell_tdata_i,
  input  logic                    res_tvalid_i,
  input  logic                    res_tready_i,
  input  logic [15:0]             res_tdata_i,
  input  logic                    res_tlast_i,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [CFG_DW-1:0]       cfg_wdata_i,
  output int                      mismatches_o,
  output int                      cells_due_o
);

  localparam int CELLS    = GRID * GRID;
  localparam int TEMP_MAX = (1 << TEMP_W) - 1;

  typedef struct packed {
    logic [TEMP_W-1:0] temp;
    logic [2:0]        row;
    logic [2:0]        col;
    logic              last;
  } cell_result_t;

  logic [STEP_BITS-1:0]  steps_q;
  logic [GAMMA_BITS-1:0] gamma_q;
  logic [TEMP_W-1:0]     plate [CELLS];
  int                    fill_pos;
  cell_result_t          due_q [$];
  cell_result_t          got, want;

  task automatic report_mismatch(input string what, input int got_val, input int want_val);
    $display("%0t ns: %s mismatch: got %0d, want %0d", $time, what, got_val, want_val);
    mismatches_o++;
  endtask

  // One explicit time step; the border keeps its values.
  function automatic void diffuse_once();
    logic [TEMP_W-1:0] nxt [CELLS];
    int u, nsum, upd;
    nxt = plate;
    for (int r = 1; r < GRID - 1; r++) begin
      for (int c = 1; c < GRID - 1; c++) begin
        u    = plate[r*GRID + c];
        nsum = int'(plate[(r-1)*GRID + c]) + int'(plate[(r+1)*GRID + c])
             + int'(plate[r*GRID + c - 1]) + int'(plate[r*GRID + c + 1]);
        // arithmetic shift floors toward minus infinity
        upd = u + ((int'(gamma_q) * (nsum - 4 * u)) >>> Q_FRAC);
        if (upd < 0) upd = 0;
        if (upd > TEMP_MAX) upd = TEMP_MAX;
        nxt[r*GRID + c] = upd[TEMP_W-1:0];
      end
    end
    plate = nxt;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steps_q      = STEP_RESET;
      gamma_q      = GAMMA_RESET;
      fill_pos     = 0;
      mismatches_o = 0;
      due_q.delete();
    end else begin
      if (res_tvalid_i && res_tready_i) begin
        got.temp = res_tdata_i[TEMP_W-1:0];
        got.row  = res_tdata_i[TEMP_W+2:TEMP_W];
        got.col  = res_tdata_i[TEMP_W+5:TEMP_W+3];
        got.last = res_tlast_i;
        if (due_q.size() == 0) begin
          report_mismatch("unexpected result, temperature", got.temp, 0);
        end else begin
          want = due_q.pop_front();
          if (got.temp !== want.temp) report_mismatch("temperature", got.temp, want.temp);
          if (got.row !== want.row) report_mismatch("row", got.row, want.row);
          if (got.col !== want.col) report_mismatch("column", got.col, want.col);
          if (got.last !== want.last) report_mismatch("tlast", got.last, want.last);
        end
      end

      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_STEP_COUNT: steps_q = cfg_wdata_i[STEP_BITS-1:0];
          CFG_GAMMA:      gamma_q = cfg_wdata_i[GAMMA_BITS-1:0];
          default: ;  // drop writes to unused indexes
        endcase
      end

      if (cell_tvalid_i && cell_tready_i) begin
        plate[fill_pos] = cell_tdata_i[TEMP_W-1:0];
        fill_pos++;
        if (fill_pos == CELLS) begin
          fill_pos = 0;
          repeat (steps_q) diffuse_once();
          for (int n = 0; n < CELLS; n++) begin
            want.temp = plate[n];
            want.row  = 3'(n / GRID);
            want.col  = 3'(n % GRID);
            want.last = (n == CELLS - 1);
            due_q.push_back(want);
          end
        end
      end
    end
    cells_due_o = due_q.size();
  end

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import hdgs_pkg::*;

  localparam int GRID     = 7;
  localparam int TEMP_W   = 7;
  localparam int CELLS    = GRID * GRID;
  localparam int TEMP_MAX = (1 << TEMP_W) - 1;

  localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_SPARE_HI = 2'd3;

  typedef enum int {
    FILL_UNIFORM,
    FILL_EXTREMES,
    FILL_FAINT,
    FILL_HOT_RIM,
    FILL_CHECKER
  } fill_e;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    s_axis_tvalid;
  logic                    s_axis_tready;
  logic [7:0]              s_axis_tdata;   // [6:0] cell_temperature
  logic                    m_axis_tvalid;
  logic                    m_axis_tready;
  logic [15:0]             m_axis_tdata;   // [6:0] temperature, [9:7] row, [12:10] column
  logic                    m_axis_tlast;
  logic                    cfg_we_i;
  logic [CFG_IDX_BITS-1:0] cfg_idx_i;
  logic [CFG_DW-1:0]       cfg_wdata_i;

  int mismatches;
  int cells_due;

  logic [TEMP_W-1:0] grid_in [CELLS];
  int                burst_left = 0;
  int                rx_mode    = 0;
  int                rx_left    = 0;

  heat_diffusion_grid_stencil_unit #(
    .GRID_SIZE (GRID),
    .TEMP_BITS (TEMP_W)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  stencil_checker #(
    .GRID   (GRID),
    .TEMP_W (TEMP_W)
  ) i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cell_tvalid_i (s_axis_tvalid),
    .cell_tready_i (s_axis_tready),
    .cell_tdata_i  (s_axis_tdata),
    .res_tvalid_i  (m_axis_tvalid),
    .res_tready_i  (m_axis_tready),
    .res_tdata_i   (m_axis_tdata),
    .res_tlast_i   (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .mismatches_o  (mismatches),
    .cells_due_o   (cells_due)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Receiver: switch between open, random, sparse and long-stall modes.
  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(20, 80);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= 1'($urandom_range(0, 1));
      2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready <= (rx_left % 16 == 0);
    endcase
  end

  task automatic send_cell(input logic [TEMP_W-1:0] temp);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, temp};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    burst_left--;
  endtask

  task automatic send_grid();
    for (int i = 0; i < CELLS; i++) send_cell(grid_in[i]);
  endtask

  task automatic fill_grid(input fill_e style);
    int r, c;
    for (int i = 0; i < CELLS; i++) begin
      r = i / GRID;
      c = i % GRID;
      case (style)
        FILL_EXTREMES: grid_in[i] = $urandom_range(0, 1) ? TEMP_W'(TEMP_MAX) : '0;
        FILL_FAINT:    grid_in[i] = TEMP_W'($urandom_range(0, 3));
        FILL_HOT_RIM: begin
          if (r == 0 || c == 0 || r == GRID - 1 || c == GRID - 1)
            grid_in[i] = TEMP_W'($urandom_range(TEMP_MAX - 20, TEMP_MAX));
          else
            grid_in[i] = TEMP_W'($urandom_range(0, 5));
        end
        FILL_CHECKER:  grid_in[i] = ((r + c) % 2 == 1) ? TEMP_W'(TEMP_MAX) : '0;
        default:       grid_in[i] = TEMP_W'($urandom_range(0, TEMP_MAX));
      endcase
    end
  endtask

  // Hold the sender until the whole grid has come back, then let the block settle.
  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (cells_due != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Upper bits of the gamma word are junk that the block must drop.
  task automatic set_run_params(input logic [STEP_BITS-1:0] steps,
                                input logic [GAMMA_BITS-1:0] gamma);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_STEP_COUNT;
    cfg_wdata_i <= steps;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_GAMMA;
    cfg_wdata_i <= {3'($urandom_range(0, 7)), gamma};
    @(posedge clk_i);
    cfg_idx_i   <= $urandom_range(0, 1) ? CFG_IDX_SPARE_LO : CFG_IDX_SPARE_HI;
    cfg_wdata_i <= CFG_DW'($urandom);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    logic [STEP_BITS-1:0]  steps;
    logic [GAMMA_BITS-1:0] gamma;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_STEP_COUNT;
    cfg_wdata_i   = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: 99 steps at gamma 0.25
    fill_grid(FILL_UNIFORM);
    send_grid();
    wait_for_results();

    // zero steps: grid comes back unchanged
    set_run_params(10'd0, 7'd64);
    fill_grid(FILL_CHECKER);
    send_grid();
    wait_for_results();

    // largest gamma on a checkerboard: saturate at both ends, negative term floors
    set_run_params(10'd1, 7'd127);
    fill_grid(FILL_CHECKER);
    send_grid();
    wait_for_results();

    set_run_params(10'd4, 7'd0);
    fill_grid(FILL_UNIFORM);
    send_grid();
    wait_for_results();

    for (int g = 0; g < 2; g++) begin
      if (g == 0 || $urandom_range(0, 2) == 0) begin
        wait_for_results();
        steps = (g == 0) ? 10'd1023 : STEP_BITS'($urandom_range(0, 12));
        case ($urandom_range(0, 3))
          0:       gamma = 7'd64;
          1:       gamma = 7'd127;
          2:       gamma = 7'd0;
          default: gamma = GAMMA_BITS'($urandom_range(1, 126));
        endcase
        set_run_params(steps, gamma);
      end
      fill_grid(fill_e'($urandom_range(0, 4)));
      send_grid();
    end

    wait_for_results();
    repeat (200) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
